// ----- hw/rtl/sod_pkg.sv -----
// sod_pkg: shared widths, reset values, register indexes and structs
// for the slot occupancy debounce labeler
// no dependencies
package sod_pkg;

    localparam int SLOT_W  = 8;
    localparam int TIME_W  = 32;
    localparam int LABEL_W = 16;
    localparam int DELAY_W = 16;
    localparam int INDEX_W = 1;

    localparam int NUM_SLOTS_DEF  = 8;
    localparam int LABEL_BITS_DEF = 16;
    localparam int TIME_BITS_DEF  = 32;

    localparam logic [DELAY_W-1:0] DEBOUNCE_RESET = 16'd50;
    localparam logic [DELAY_W-1:0] DETECT_RESET   = 16'd500;

    localparam logic [INDEX_W-1:0] CFG_SETTLE_MS    = 1'b0;
    localparam logic [INDEX_W-1:0] CFG_DETECT_DELAY = 1'b1;

    typedef logic [SLOT_W-1:0][LABEL_W-1:0] label_vec_t;

    typedef struct packed {
        logic              advance;
        logic [SLOT_W-1:0] raw;
        logic [TIME_W-1:0] now;
    } step_t;

    typedef struct packed {
        logic [SLOT_W-1:0]  stable_switches;
        logic               check_done;
        logic [SLOT_W-1:0]  new_slots_mask;
        logic [LABEL_W-1:0] assigned_number;
        label_vec_t         labels;
    } result_t;

endpackage

// ----- hw/rtl/sod_if.sv -----
// sod_sample_if and sod_result_if: valid/ready channels for samples and results
// depends on sod_pkg
interface sod_sample_if;
    logic                       valid;
    logic                       ready;
    logic [sod_pkg::SLOT_W-1:0] raw_switches;
    logic [sod_pkg::TIME_W-1:0] time_ms;

    modport source (output valid, output raw_switches, output time_ms, input ready);
    modport sink   (input valid, input raw_switches, input time_ms, output ready);
endinterface

interface sod_result_if;
    logic                        valid;
    logic                        ready;
    logic [sod_pkg::SLOT_W-1:0]  stable_switches;
    logic                        check_done;
    logic [sod_pkg::SLOT_W-1:0]  new_slots_mask;
    logic [sod_pkg::LABEL_W-1:0] assigned_number;
    logic [sod_pkg::LABEL_W-1:0] label_slot0;
    logic [sod_pkg::LABEL_W-1:0] label_slot1;
    logic [sod_pkg::LABEL_W-1:0] label_slot2;
    logic [sod_pkg::LABEL_W-1:0] label_slot3;
    logic [sod_pkg::LABEL_W-1:0] label_slot4;
    logic [sod_pkg::LABEL_W-1:0] label_slot5;
    logic [sod_pkg::LABEL_W-1:0] label_slot6;
    logic [sod_pkg::LABEL_W-1:0] label_slot7;

    modport source (
        output valid, output stable_switches, output check_done, output new_slots_mask,
        output assigned_number, output label_slot0, output label_slot1,
        output label_slot2, output label_slot3, output label_slot4, output label_slot5,
        output label_slot6, output label_slot7, input ready
    );
    modport sink (
        input valid, input stable_switches, input check_done, input new_slots_mask,
        input assigned_number, input label_slot0, input label_slot1,
        input label_slot2, input label_slot3, input label_slot4, input label_slot5,
        input label_slot6, input label_slot7, output ready
    );
endinterface

// ----- hw/rtl/sod_debounce.sv -----
// sod_debounce: per-channel change stamps and stable levels
// depends on sod_pkg
module sod_debounce #(
    parameter int NUM_SLOTS = sod_pkg::NUM_SLOTS_DEF,
    parameter int TIME_BITS = sod_pkg::TIME_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  sod_pkg::step_t              step,
    input  logic [sod_pkg::DELAY_W-1:0] settle_ms,
    output logic [NUM_SLOTS-1:0]        stable_next
);

    logic [NUM_SLOTS-1:0]                prev_raw_reg;
    logic [NUM_SLOTS-1:0]                stable_reg;
    logic [NUM_SLOTS-1:0][TIME_BITS-1:0] stamp_reg;
    logic [NUM_SLOTS-1:0][TIME_BITS-1:0] stamp_next;
    logic [NUM_SLOTS-1:0][TIME_BITS-1:0] elapsed;
    logic [NUM_SLOTS-1:0]                raw;
    logic [TIME_BITS-1:0]                now;
    logic [TIME_BITS-1:0]                delay;

    assign raw   = step.raw[NUM_SLOTS-1:0];
    assign now   = step.now[TIME_BITS-1:0];
    assign delay = TIME_BITS'(settle_ms);

    always_comb
    begin
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            stamp_next[i] = (raw[i] != prev_raw_reg[i]) ? now : stamp_reg[i];
            elapsed[i]    = now - stamp_next[i];
            stable_next[i] = (elapsed[i] > delay) ? raw[i] : stable_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_raw_reg <= '0;
            stable_reg   <= '0;
            stamp_reg    <= '0;
        end
        else if (step.advance)
        begin
            prev_raw_reg <= raw;
            stable_reg   <= stable_next;
            stamp_reg    <= stamp_next;
        end
    end

endmodule

// ----- hw/rtl/sod_labeler.sv -----
// sod_labeler: detection arming, slot evaluation and container labels
// depends on sod_pkg; takes debounced levels from sod_debounce
module sod_labeler #(
    parameter int NUM_SLOTS  = sod_pkg::NUM_SLOTS_DEF,
    parameter int LABEL_BITS = sod_pkg::LABEL_BITS_DEF,
    parameter int TIME_BITS  = sod_pkg::TIME_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  sod_pkg::step_t              step,
    input  logic [NUM_SLOTS-1:0]        stable_next,
    input  logic [sod_pkg::DELAY_W-1:0] detect_delay,
    output sod_pkg::result_t            result_next
);

    localparam logic [LABEL_BITS-1:0] LABEL_MAX = {LABEL_BITS{1'b1}};
    localparam logic [LABEL_BITS-1:0] LABEL_ONE = LABEL_BITS'(1);

    logic                                 armed_reg;
    logic                                 armed_next;
    logic [TIME_BITS-1:0]                 dstamp_reg;
    logic [TIME_BITS-1:0]                 dstamp_next;
    logic [LABEL_BITS-1:0]                next_label_reg;
    logic [LABEL_BITS-1:0]                next_label_next;
    logic [NUM_SLOTS-1:0][LABEL_BITS-1:0] labels_reg;
    logic [NUM_SLOTS-1:0][LABEL_BITS-1:0] labels_next;
    logic [NUM_SLOTS-1:0]                 new_mask;
    logic [NUM_SLOTS-1:0]                 raw;
    logic [TIME_BITS-1:0]                 now;
    logic [TIME_BITS-1:0]                 elapsed;
    logic                                 done;
    sod_pkg::label_vec_t                  labels_out;

    assign raw     = step.raw[NUM_SLOTS-1:0];
    assign now     = step.now[TIME_BITS-1:0];
    assign elapsed = now - dstamp_reg;

    always_comb
    begin
        armed_next  = armed_reg;
        dstamp_next = dstamp_reg;
        done        = 1'b0;
        if (!armed_reg)
        begin
            if ((stable_next ^ raw) != '0)
            begin
                armed_next  = 1'b1;
                dstamp_next = now;
            end
        end
        else if (elapsed > TIME_BITS'(detect_delay))
        begin
            armed_next = 1'b0;
            done       = 1'b1;
        end

        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            new_mask[i] = done && stable_next[i] && (labels_reg[i] == '0);
            if (new_mask[i])
                labels_next[i] = next_label_reg;
            else if (done && !stable_next[i])
                labels_next[i] = '0;
            else
                labels_next[i] = labels_reg[i];
        end

        if (new_mask != '0)
            next_label_next = (next_label_reg == LABEL_MAX) ? LABEL_ONE
                                                            : next_label_reg + LABEL_ONE;
        else
            next_label_next = next_label_reg;
    end

    for (genvar g = 0; g < sod_pkg::SLOT_W; g++)
    begin : g_label_out
        if (g < NUM_SLOTS)
        begin : g_used
            assign labels_out[g] = sod_pkg::LABEL_W'(labels_next[g]);
        end
        else
        begin : g_unused
            assign labels_out[g] = '0;
        end
    end

    always_comb
    begin
        result_next.stable_switches = sod_pkg::SLOT_W'(stable_next);
        result_next.check_done      = done;
        result_next.new_slots_mask  = sod_pkg::SLOT_W'(new_mask);
        result_next.assigned_number = (new_mask != '0)
                                      ? sod_pkg::LABEL_W'(next_label_reg) : '0;
        result_next.labels          = labels_out;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg      <= 1'b0;
            dstamp_reg     <= '0;
            next_label_reg <= LABEL_ONE;
            labels_reg     <= '0;
        end
        else if (step.advance)
        begin
            armed_reg      <= armed_next;
            dstamp_reg     <= dstamp_next;
            next_label_reg <= next_label_next;
            labels_reg     <= labels_next;
        end
    end

endmodule

// ----- hw/rtl/slot_occupancy_debounce_labeler.sv -----
// slot_occupancy_debounce_labeler: top level, sample register, result register
// and configuration registers
// depends on sod_pkg, sod_if, sod_debounce, sod_labeler
//
// usage
//   sample channel (valid/ready): eight raw switch levels and a millisecond stamp
//   result channel (valid/ready): debounced levels, evaluation flag, newly
//   labelled slots, the number given to them and the label of every slot
//   cfg_we/cfg_index/cfg_data: index 0 debounce delay, index 1 detection delay,
//   write only while no transfer is in flight
// timing
//   a sample is held in the sample register, worked on there by the debounce and
//   labelling logic, and loaded into the result register once that register is
//   empty or its result is taken
//   one sample per cycle sustained while results are taken; the state update path
//   from sample register to debounce, detection and label registers is combinational
// reset
//   delays return to 50 and 500, all slots empty, next container number 1
// stall
//   a held result stops the pipe only once the sample register is also full;
//   no transfer is lost or repeated
module slot_occupancy_debounce_labeler #(
    parameter int NUM_SLOTS  = sod_pkg::NUM_SLOTS_DEF,
    parameter int LABEL_BITS = sod_pkg::LABEL_BITS_DEF,
    parameter int TIME_BITS  = sod_pkg::TIME_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    sod_sample_if.sink                  sample,
    sod_result_if.source                result,
    input  logic                        cfg_we,
    input  logic [sod_pkg::INDEX_W-1:0] cfg_index,
    input  logic [sod_pkg::DELAY_W-1:0] cfg_data
);

    logic                        in_valid_reg;
    logic [sod_pkg::SLOT_W-1:0]  in_raw_reg;
    logic [sod_pkg::TIME_W-1:0]  in_time_reg;
    logic                        out_valid_reg;
    sod_pkg::result_t            out_reg;
    sod_pkg::result_t            result_next;
    logic [sod_pkg::DELAY_W-1:0] settle_ms_reg;
    logic [sod_pkg::DELAY_W-1:0] detect_delay_reg;
    logic [NUM_SLOTS-1:0]        stable_next;
    logic                        advance;
    sod_pkg::step_t              step;

    assign advance      = in_valid_reg && (!out_valid_reg || result.ready);
    assign sample.ready = !in_valid_reg || advance;

    assign step.advance = advance;
    assign step.raw     = in_raw_reg;
    assign step.now     = in_time_reg;

    sod_debounce #(
        .NUM_SLOTS (NUM_SLOTS),
        .TIME_BITS (TIME_BITS)
    ) u_debounce (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .settle_ms   (settle_ms_reg),
        .stable_next (stable_next)
    );

    sod_labeler #(
        .NUM_SLOTS  (NUM_SLOTS),
        .LABEL_BITS (LABEL_BITS),
        .TIME_BITS  (TIME_BITS)
    ) u_labeler (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .stable_next  (stable_next),
        .detect_delay (detect_delay_reg),
        .result_next  (result_next)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settle_ms_reg    <= sod_pkg::DEBOUNCE_RESET;
            detect_delay_reg <= sod_pkg::DETECT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                sod_pkg::CFG_SETTLE_MS:    settle_ms_reg    <= cfg_data;
                sod_pkg::CFG_DETECT_DELAY: detect_delay_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // sample register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (sample.ready)
            in_valid_reg <= sample.valid;
    end

    always_ff @(posedge clk)
    begin
        if (sample.valid && sample.ready)
        begin
            in_raw_reg  <= sample.raw_switches;
            in_time_reg <= sample.time_ms;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_reg <= result_next;
    end

    assign result.valid           = out_valid_reg;
    assign result.stable_switches = out_reg.stable_switches;
    assign result.check_done      = out_reg.check_done;
    assign result.new_slots_mask  = out_reg.new_slots_mask;
    assign result.assigned_number = out_reg.assigned_number;
    assign result.label_slot0     = out_reg.labels[0];
    assign result.label_slot1     = out_reg.labels[1];
    assign result.label_slot2     = out_reg.labels[2];
    assign result.label_slot3     = out_reg.labels[3];
    assign result.label_slot4     = out_reg.labels[4];
    assign result.label_slot5     = out_reg.labels[5];
    assign result.label_slot6     = out_reg.labels[6];
    assign result.label_slot7     = out_reg.labels[7];

endmodule
